[src/multichannel_moving_average_max_defines.svh]
// ---------------------------------------------------------------------------
// Moving average maximum: assertion macros
// Shared property wrappers; the enclosing module provides clk and rst_n.
// ---------------------------------------------------------------------------
`ifndef MULTICHANNEL_MOVING_AVERAGE_MAX_DEFINES_SVH
`define MULTICHANNEL_MOVING_AVERAGE_MAX_DEFINES_SVH

// Checked on every clock edge outside reset.
`define MMAM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define MMAM_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/mmam_pkg.sv]
// ---------------------------------------------------------------------------
// Moving average maximum: package
// Default sizes and the configuration register width.
// ---------------------------------------------------------------------------
package mmam_pkg;

  localparam int unsigned DEF_HISTORY_DEPTH          = 16;
  localparam int unsigned DEF_MAX_CHANNELS           = 20;
  localparam int unsigned DEF_BASE_CHANNELS          = 2;
  localparam int unsigned DEF_CHANNELS_PER_EXTENSION = 4;
  localparam int unsigned DEF_SAMPLE_BITS            = 10;

  localparam int unsigned EXT_W   = 2;
  localparam int unsigned EXT_MAX = (1 << EXT_W) - 1;

endpackage

[src/mmam_hist.sv]
// ---------------------------------------------------------------------------
// Moving average maximum: history memory
// Single-port-write, registered-read sample store with a clearing pass
// that zeroes every entry after reset.
// ---------------------------------------------------------------------------
module mmam_hist #(
  parameter int unsigned DEPTH  = mmam_pkg::DEF_MAX_CHANNELS * mmam_pkg::DEF_HISTORY_DEPTH,
  parameter int unsigned DATA_W = mmam_pkg::DEF_SAMPLE_BITS,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  output logic              clr_busy
);
  import mmam_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;
  logic [ADDR_W-1:0] clr_addr_r;
  logic              clr_busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      clr_busy_r <= 1'b1;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + ADDR_W'(1);
      if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_addr_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data  = rd_data_r;
  assign clr_busy = clr_busy_r;

endmodule

[src/multichannel_moving_average_max.sv]
// ---------------------------------------------------------------------------
// Multichannel moving average maximum
// Per-channel 16-sample moving averages with the largest one per frame.
// ---------------------------------------------------------------------------
// Samples enter on in_sample/in_valid/in_stall in channel order, one frame
// being BASE_CHANNELS + CHANNELS_PER_EXTENSION * extension_count channels,
// capped at MAX_CHANNELS. After the last sample of a frame one request leaves
// on out_weight/out_valid/out_stall carrying the largest channel average.
// The user must write the extension count on cfg_extension_count/cfg_valid/
// cfg_ready only while the block is idle; the block does not enforce this.
// cfg_ready is always high. A sample is accepted every cycle while in_stall
// is low. The history memory is read as a sample is taken and written back
// by the update stage, which loads a frame result into the output register.
// After reset the history memory is cleared one entry per cycle, covering
// all MAX_CHANNELS * HISTORY_DEPTH entries; in_stall is high during that
// pass. Running sums, slot, channel counter and maximum reset at once.
// When the receiver stalls, a finished result is held in the output
// register; samples keep entering until the last sample of the next frame,
// which waits in the update stage.
// ---------------------------------------------------------------------------
`include "multichannel_moving_average_max_defines.svh"

module multichannel_moving_average_max #(
  parameter int unsigned HISTORY_DEPTH          = mmam_pkg::DEF_HISTORY_DEPTH,
  parameter int unsigned MAX_CHANNELS           = mmam_pkg::DEF_MAX_CHANNELS,
  parameter int unsigned BASE_CHANNELS          = mmam_pkg::DEF_BASE_CHANNELS,
  parameter int unsigned CHANNELS_PER_EXTENSION = mmam_pkg::DEF_CHANNELS_PER_EXTENSION,
  parameter int unsigned SAMPLE_BITS            = mmam_pkg::DEF_SAMPLE_BITS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [SAMPLE_BITS-1:0]     in_sample,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [SAMPLE_BITS-1:0]     out_weight,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [mmam_pkg::EXT_W-1:0] cfg_extension_count
);
  import mmam_pkg::*;

  localparam int unsigned SLOT_W  = $clog2(HISTORY_DEPTH);
  localparam int unsigned CH_W    = $clog2(MAX_CHANNELS);
  localparam int unsigned DEPTH   = MAX_CHANNELS * HISTORY_DEPTH;
  localparam int unsigned ADDR_W  = $clog2(DEPTH);
  localparam int unsigned SUM_W   = SAMPLE_BITS + SLOT_W;
  localparam int unsigned RECIP_W = SUM_W + 1;
  localparam int unsigned SHIFT   = SUM_W + SLOT_W;
  localparam int unsigned RECIP   = ((1 << SHIFT) + HISTORY_DEPTH - 1) / HISTORY_DEPTH;
  localparam int unsigned PROD_W  = SUM_W + RECIP_W;
  localparam int unsigned RAW_MAX = BASE_CHANNELS + CHANNELS_PER_EXTENSION * EXT_MAX;
  localparam int unsigned RAW_W   = $clog2(RAW_MAX + 1);
  localparam int unsigned CNT_W   = $clog2(MAX_CHANNELS + 1);
  localparam int unsigned CW      = (RAW_W > CNT_W) ? RAW_W : CNT_W;

  logic [EXT_W-1:0]       ext_r;
  logic [CH_W-1:0]        ch_cnt_r;
  logic [SLOT_W-1:0]      slot_r;
  logic [CW-1:0]          flen_raw;
  logic [CW-1:0]          flen;
  logic                   last0;
  logic                   in_acc;
  logic [ADDR_W-1:0]      addr0;

  logic                   s1_valid_r;
  logic                   s1_last_r;
  logic [CH_W-1:0]        s1_ch_r;
  logic [ADDR_W-1:0]      s1_addr_r;
  logic [SAMPLE_BITS-1:0] s1_sample_r;
  logic                   s1_adv;

  logic [SUM_W-1:0]       sums_r [MAX_CHANNELS];
  logic [SUM_W-1:0]       sum_new;
  logic [PROD_W-1:0]      prod;
  logic [SAMPLE_BITS-1:0] avg;
  logic [SAMPLE_BITS-1:0] fmax_r;
  logic [SAMPLE_BITS-1:0] fmax_cand;

  logic                   out_valid_r;
  logic [SAMPLE_BITS-1:0] out_weight_r;

  logic [SAMPLE_BITS-1:0] old_sample;
  logic                   clr_busy;

  mmam_hist #(
    .DEPTH  (DEPTH),
    .DATA_W (SAMPLE_BITS),
    .ADDR_W (ADDR_W)
  ) u_hist (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_acc),
    .rd_addr  (addr0),
    .rd_data  (old_sample),
    .wr_en    (s1_adv),
    .wr_addr  (s1_addr_r),
    .wr_data  (s1_sample_r),
    .clr_busy (clr_busy)
  );

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      ext_r <= cfg_extension_count;
    end
  end

  assign flen_raw = CW'(BASE_CHANNELS) + CW'(CHANNELS_PER_EXTENSION) * CW'(ext_r);
  assign flen     = (flen_raw > CW'(MAX_CHANNELS)) ? CW'(MAX_CHANNELS) : flen_raw;
  assign last0    = (CW'(ch_cnt_r) + CW'(1)) >= flen;
  assign addr0    = ADDR_W'(ch_cnt_r) * ADDR_W'(HISTORY_DEPTH) + ADDR_W'(slot_r);

  assign s1_adv   = s1_valid_r && !(s1_last_r && out_valid_r && out_stall);
  assign in_stall = clr_busy || (s1_valid_r && !s1_adv);
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_cnt_r <= '0;
      slot_r   <= '0;
    end else if (in_acc) begin
      if (last0) begin
        ch_cnt_r <= '0;
        slot_r   <= (slot_r == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : slot_r + SLOT_W'(1);
      end else begin
        ch_cnt_r <= ch_cnt_r + CH_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_last_r   <= last0;
      s1_ch_r     <= ch_cnt_r;
      s1_addr_r   <= addr0;
      s1_sample_r <= in_sample;
    end
  end

  assign sum_new   = sums_r[s1_ch_r] - SUM_W'(old_sample) + SUM_W'(s1_sample_r);
  assign prod      = PROD_W'(sum_new) * PROD_W'(RECIP);
  assign avg       = prod[SHIFT +: SAMPLE_BITS];
  assign fmax_cand = (avg > fmax_r) ? avg : fmax_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        sums_r[i] <= '0;
      end
      fmax_r <= '0;
    end else if (s1_adv) begin
      sums_r[s1_ch_r] <= sum_new;
      fmax_r          <= s1_last_r ? '0 : fmax_cand;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_r) begin
      out_weight_r <= fmax_cand;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_weight = out_weight_r;

  `MMAM_ASSERT(a_result_after_last, (s1_valid_r && s1_last_r && s1_adv) |=> out_valid_r, "frame end gave no result")
  `MMAM_ASSERT(a_no_update_in_clear, !(clr_busy && s1_valid_r), "sample in flight during history clear")
  `MMAM_ASSERT(a_channel_range, {1'b0, ch_cnt_r} < (CH_W + 1)'(MAX_CHANNELS), "channel counter out of range")
  `MMAM_ASSERT_RST(a_reset_idle, !rst_n |=> (!out_valid_r && !s1_valid_r), "pipeline not idle after reset")

endmodule

[tb/sv/frame_max_checker.sv]
// ---------------------------------------------------------------------------
// Frame maximum checker
// Watches the sample, weight and configuration channels of the moving
// average block, keeps its own copy of the channel histories, running sums,
// slot, channel counter and frame maximum, and compares every weight request
// with the oldest predicted weight. Reports the number of failures and the
// number of weights still awaited.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module frame_max_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic [mmam_pkg::DEF_SAMPLE_BITS-1:0] in_sample,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic [mmam_pkg::DEF_SAMPLE_BITS-1:0] out_weight,
  input  logic                                 cfg_valid,
  input  logic                                 cfg_ready,
  input  logic [mmam_pkg::EXT_W-1:0]           cfg_extension_count,
  output int                                   failures,
  output int                                   pending
);

  localparam int unsigned DEPTH   = mmam_pkg::DEF_HISTORY_DEPTH;
  localparam int unsigned CHANS   = mmam_pkg::DEF_MAX_CHANNELS;
  localparam int unsigned BASE    = mmam_pkg::DEF_BASE_CHANNELS;
  localparam int unsigned PER_EXT = mmam_pkg::DEF_CHANNELS_PER_EXTENSION;
  localparam int unsigned SB      = mmam_pkg::DEF_SAMPLE_BITS;
  localparam int unsigned SUM_W   = SB + $clog2(DEPTH);
  localparam int unsigned SLOT_W  = $clog2(DEPTH);
  localparam int unsigned CHAN_W  = $clog2(CHANS);

  logic [SB-1:0]                 history [CHANS][DEPTH];
  logic [SUM_W-1:0]              sums [CHANS];
  logic [SLOT_W-1:0]             slot;
  logic [CHAN_W-1:0]             chan;
  logic [SB-1:0]                 frame_max;
  logic [mmam_pkg::EXT_W-1:0]    ext_count;
  logic [SB-1:0]                 expected_weights [$];
  logic [SB-1:0]                 oldest;

  function automatic int unsigned frame_channels(input logic [mmam_pkg::EXT_W-1:0] e);
    int unsigned n;
    n = BASE + PER_EXT * e;
    if (n > CHANS) begin
      n = CHANS;
    end
    return n;
  endfunction

  task automatic absorb_sample(input logic [SB-1:0] s);
    int unsigned   ch;
    logic [SB-1:0] avg;
    ch = chan;
    if (ch >= CHANS) begin
      ch = CHANS - 1;
    end
    sums[ch]          = sums[ch] - history[ch][slot] + s;
    history[ch][slot] = s;
    avg = SB'(sums[ch] / DEPTH);
    if (avg > frame_max) begin
      frame_max = avg;
    end
    if (ch + 1 >= frame_channels(ext_count)) begin
      expected_weights.push_back(frame_max);
      frame_max = '0;
      chan      = '0;
      slot      = (slot == DEPTH - 1) ? '0 : slot + SLOT_W'(1);
    end else begin
      chan = CHAN_W'(ch + 1);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANS; c++) begin
        sums[c] = '0;
        for (int d = 0; d < DEPTH; d++) begin
          history[c][d] = '0;
        end
      end
      slot      = '0;
      chan      = '0;
      frame_max = '0;
      ext_count = '0;
      failures  = 0;
      expected_weights.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        ext_count = cfg_extension_count;
      end
      if (out_valid && !out_stall) begin
        if (expected_weights.size() == 0) begin
          $error("weight: no request expected, actual %0d", out_weight);
          failures++;
        end else begin
          oldest = expected_weights.pop_front();
          if (out_weight !== oldest) begin
            $error("weight: expected %0d, actual %0d", oldest, out_weight);
            failures++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        absorb_sample(in_sample);
      end
    end
    pending = expected_weights.size();
  end

endmodule

[tb/sv/testbench.sv]
// ---------------------------------------------------------------------------
// Moving average maximum testbench
// Drives samples in frame order through directed frames and random phases
// with varied extension counts, random idle bursts on both channels and one
// long output hold, while the checker predicts every frame weight.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned SB = mmam_pkg::DEF_SAMPLE_BITS;
  localparam logic [SB-1:0] SAMPLE_MAX = {SB{1'b1}};

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic [SB-1:0]              in_sample;
  logic                       out_valid;
  logic                       out_stall;
  logic [SB-1:0]              out_weight;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [mmam_pkg::EXT_W-1:0] cfg_extension_count;
  int                         failures;
  int                         pending;
  bit                         idle_on      = 1'b0;
  bit                         hold_request = 1'b0;
  bit                         hold_done    = 1'b0;
  int                         stall_left   = 0;

  multichannel_moving_average_max DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_sample           (in_sample),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_weight          (out_weight),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_extension_count (cfg_extension_count)
  );

  frame_max_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_sample           (in_sample),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_weight          (out_weight),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_extension_count (cfg_extension_count),
    .failures            (failures),
    .pending             (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("testbench: errors");
    $finish;
  end

  // The receiver stalls in short bursts, or for a long stretch on request.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (hold_request && !hold_done) begin
        hold_done  = 1'b1;
        out_stall  <= 1'b1;
        stall_left = 199;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_stall  <= 1'b1;
        stall_left = $urandom_range(0, 2);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic [SB-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return SAMPLE_MAX;
      2: return SB'($urandom_range(900, 1023));
      default: return SB'($urandom);
    endcase
  endfunction

  task automatic send_sample(input logic [SB-1:0] v);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_sample <= v;
    in_valid  <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic write_extension(input logic [mmam_pkg::EXT_W-1:0] e);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_extension_count <= e;
    cfg_valid           <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int sent;
    int burst;
    in_valid            = 1'b0;
    in_sample           = '0;
    cfg_valid           = 1'b0;
    cfg_extension_count = '0;
    rst_n               = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Short frames at both extremes of the sample range.
    write_extension('0);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MAX);
    send_sample('0);
    send_sample('0);
    write_extension(mmam_pkg::EXT_W'(mmam_pkg::EXT_MAX));
    for (int i = 0; i < 14; i++) begin
      send_sample((i % 2 == 0) ? SAMPLE_MAX : '0);
    end
    // A shorter frame length set mid-frame ends the frame on the next request.
    for (int i = 0; i < 7; i++) begin
      send_sample(SAMPLE_MAX);
    end
    write_extension(mmam_pkg::EXT_W'(1));
    send_sample(SAMPLE_MAX);

    idle_on = 1'b1;
    sent    = 0;
    for (int phase = 0; sent < 950; phase++) begin
      write_extension(mmam_pkg::EXT_W'($urandom_range(0, mmam_pkg::EXT_MAX)));
      if (phase == 2) begin
        hold_request = 1'b1;
        burst        = 120;
      end else begin
        burst = $urandom_range(20, 120);
      end
      for (int i = 0; i < burst; i++) begin
        send_sample(pick_sample());
      end
      sent += burst;
    end

    idle_on = 1'b0;
    write_extension(mmam_pkg::EXT_W'($urandom_range(0, mmam_pkg::EXT_MAX)));
    for (int i = 0; i < 150; i++) begin
      send_sample(pick_sample());
    end
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (failures == 0 && pending == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+src
src/mmam_pkg.sv
src/mmam_hist.sv
src/multichannel_moving_average_max.sv
tb/sv/frame_max_checker.sv
tb/sv/testbench.sv
